// ===== src/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// shared types and constants of the byte ring buffer with delimiter search
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int CAP_W      = 11;
   localparam int FILL_W     = 11;
   localparam int WIN_W      = 11;
   localparam int CNT_W      = 7;
   localparam int NL_W       = 4;
   localparam int NEEDLE_W   = 64;
   localparam int CSR_IDX_W  = 2;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int MAX_NEEDLE_DEFAULT = 8;
   localparam int MAX_READ_DEFAULT   = 64;
   localparam int CAP_RESET          = 1024;

   localparam logic [NEEDLE_W-1:0] NEEDLE_RESET = 64'd2573;
   localparam logic [NL_W-1:0]     NL_RESET     = 4'd2;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_FIND  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY   = 2'd0,
      CSR_NEEDLE     = 2'd1,
      CSR_NEEDLE_LEN = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic needs_scan;
      logic issue_more;
      logic hit;
   } status_type;

endpackage

// ===== src/brb_ram.sv =====
// ----------------------------------------------------------------------------
// brb_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/brb_ctrl.sv =====
// ----------------------------------------------------------------------------
// brb_ctrl
// sequencer: takes items, steps the scan over the buffer, ends each item
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  brb_pkg::status_type status,
   output brb_pkg::cmd_type    cmd,
   output logic               busy
);

   import brb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (status.needs_scan) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            priority if (status.hit) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.issue_more) begin
               cmd.issue = 1'b1;
            end else begin
               // last byte arrives in this cycle
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== src/brb_dp.sv =====
// ----------------------------------------------------------------------------
// brb_dp
// datapath: pointers, registers, storage, delimiter compare and result register
// ----------------------------------------------------------------------------
module brb_dp #(
   parameter int DEPTH      = brb_pkg::DEPTH_DEFAULT,
   parameter int MAX_NEEDLE = brb_pkg::MAX_NEEDLE_DEFAULT,
   parameter int MAX_READ   = brb_pkg::MAX_READ_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  brb_pkg::cmd_type              cmd,
   output brb_pkg::status_type           status,
   input  logic [1:0]                    req_action,
   input  logic [7:0]                    req_data_byte,
   input  logic [brb_pkg::CNT_W-1:0]     req_read_count,
   input  logic [brb_pkg::WIN_W-1:0]     req_search_window,
   input  logic                          csr_write_enable,
   input  logic [brb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [brb_pkg::NEEDLE_W-1:0]  csr_write_data,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_write_accepted,
   output logic                          rsp_found,
   output logic [brb_pkg::WIN_W-1:0]     rsp_match_end_offset,
   output logic [brb_pkg::FILL_W-1:0]    rsp_fill_level,
   output logic                          rsp_last
);

   import brb_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int MW = (PW + 1 > CAP_W + 1) ? PW + 1 : CAP_W + 1;
   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
   localparam logic [CAP_W-1:0] CAP_INIT  = (CAP_RESET > DEPTH) ? CAP_W'(DEPTH)
                                                                 : CAP_W'(CAP_RESET);
   localparam logic [NL_W-1:0]  NL_MAX    = NL_W'(MAX_NEEDLE);
   localparam logic [CNT_W-1:0] READ_MAX  = CNT_W'(MAX_READ);

   // configuration
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [NEEDLE_W-1:0] needle_ff, needle_in;
   logic [NL_W-1:0]     nl_ff, nl_in;

   // buffer state
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic          lww_ff, lww_in;

   // scan state
   logic [PW-1:0]     sp_ff, sp_in;
   logic [WIN_W-1:0]  target_ff, target_in;
   logic [WIN_W-1:0]  issued_ff, issued_in;
   logic [WIN_W-1:0]  rx_ff, rx_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              find_ff, find_in;
   logic              dv_ff;
   logic [7:0]        hist_ff [MAX_NEEDLE];
   logic [7:0]        hist_in [MAX_NEEDLE];

   // result register
   logic              strobe_ff, strobe_in;
   logic [7:0]        byte_ff, byte_in;
   logic              valid_ff, valid_in;
   logic              acc_ff, acc_in;
   logic              found_ff, found_in;
   logic [WIN_W-1:0]  off_ff, off_in;
   logic [FILL_W-1:0] lvl_ff, lvl_in;
   logic              last_ff, last_in;

   logic [7:0]        rdata;
   logic [MW-1:0]     cap_m, rp_m, wp_m, sp1_m, wp1_m, held_m;
   logic [FILL_W-1:0] fill_now;
   logic              full;
   logic              do_write;
   logic [CNT_W-1:0]  cnt_sat;
   logic [FILL_W-1:0] read_n;
   logic              find_ok;
   logic [WIN_W-1:0]  rx1;
   logic [7:0]        win [MAX_NEEDLE];
   logic              match;
   logic [NL_W-1:0]   nidx;
   logic [CAP_W-1:0]  cap_wr;
   logic [NL_W-1:0]   nl_wr;

   assign cap_m = MW'(cap_ff);
   assign rp_m  = MW'(rp_ff);
   assign wp_m  = MW'(wp_ff);
   assign sp1_m = MW'(sp_ff) + MW'(1);
   assign wp1_m = wp_m + MW'(1);

   always_comb begin
      if (rp_ff == wp_ff) begin
         held_m = lww_ff ? cap_m : '0;
      end else if (wp_m >= rp_m) begin
         held_m = wp_m - rp_m;
      end else begin
         held_m = wp_m + cap_m - rp_m;
      end
   end

   assign fill_now = held_m[FILL_W-1:0];
   assign full     = lww_ff && (rp_ff == wp_ff);
   assign do_write = cmd.accept && (req_action == ACT_WRITE) && !full;
   assign cnt_sat  = (req_read_count > READ_MAX) ? READ_MAX : req_read_count;
   assign read_n   = (FILL_W'(cnt_sat) > fill_now) ? fill_now : FILL_W'(cnt_sat);
   assign find_ok  = !((fill_now < req_search_window) || (fill_now < FILL_W'(nl_ff))
                       || (WIN_W'(nl_ff) > req_search_window));
   assign rx1      = rx_ff + WIN_W'(1);

   // newest byte first
   always_comb begin
      win[0] = rdata;
      for (int k = 1; k < MAX_NEEDLE; k++) begin
         win[k] = hist_ff[k-1];
      end
   end

   always_comb begin
      match = dv_ff && find_ff && (rx1 >= WIN_W'(nl_ff));
      nidx  = '0;
      for (int k = 0; k < MAX_NEEDLE; k++) begin
         nidx = nl_ff - NL_W'(k) - NL_W'(1);
         if ((NL_W'(k) < nl_ff) && (win[k] != needle_ff[8*nidx[2:0] +: 8])) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      unique case (req_action)
         ACT_READ:  status.needs_scan = (read_n != '0);
         ACT_FIND:  status.needs_scan = find_ok;
         ACT_WRITE: status.needs_scan = 1'b0;
         default:   status.needs_scan = 1'b0;
      endcase
      status.issue_more = (issued_ff < target_ff);
      status.hit        = match;
   end

   always_comb begin
      cap_wr = csr_write_data[CAP_W-1:0];
      if (cap_wr == '0) begin
         cap_wr = CAP_W'(1);
      end else if (cap_wr > CAP_MAX) begin
         cap_wr = CAP_MAX;
      end
      nl_wr = csr_write_data[NL_W-1:0];
      if (nl_wr == '0) begin
         nl_wr = NL_W'(1);
      end else if (nl_wr > NL_MAX) begin
         nl_wr = NL_MAX;
      end
   end

   always_comb begin
      cap_in    = cap_ff;
      needle_in = needle_ff;
      nl_in     = nl_ff;
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      lww_in    = lww_ff;
      sp_in     = sp_ff;
      target_in = target_ff;
      issued_in = issued_ff;
      rx_in     = rx_ff;
      fill_in   = fill_ff;
      find_in   = find_ff;
      hist_in   = hist_ff;
      strobe_in = 1'b0;
      byte_in   = '0;
      valid_in  = 1'b0;
      acc_in    = 1'b0;
      found_in  = 1'b0;
      off_in    = '0;
      lvl_in    = lvl_ff;
      last_in   = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CAPACITY: begin
               cap_in = cap_wr;
               rp_in  = '0;
               wp_in  = '0;
               lww_in = 1'b0;
            end
            CSR_NEEDLE:     needle_in = csr_write_data;
            CSR_NEEDLE_LEN: nl_in     = nl_wr;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         sp_in     = rp_ff;
         issued_in = '0;
         rx_in     = '0;
         find_in   = (req_action == ACT_FIND);
         fill_in   = (req_action == ACT_READ) ? fill_now - read_n : fill_now;
         target_in = (req_action == ACT_READ) ? WIN_W'(read_n) : req_search_window;
         if (!status.needs_scan) begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            lvl_in    = fill_now;
            if (do_write) begin
               acc_in = 1'b1;
               lvl_in = fill_now + FILL_W'(1);
               wp_in  = (wp1_m == cap_m) ? '0 : wp_ff + PW'(1);
               lww_in = 1'b1;
            end
         end
      end

      if (cmd.issue) begin
         sp_in     = (sp1_m == cap_m) ? '0 : sp_ff + PW'(1);
         issued_in = issued_ff + WIN_W'(1);
      end

      if (dv_ff) begin
         rx_in = rx1;
         for (int k = 0; k < MAX_NEEDLE; k++) begin
            hist_in[k] = win[k];
         end
         if (!find_ff) begin
            strobe_in = 1'b1;
            byte_in   = rdata;
            valid_in  = 1'b1;
            lvl_in    = fill_ff;
            last_in   = (rx1 == target_ff);
         end
      end

      if (cmd.finish) begin
         if (find_ff) begin
            strobe_in = 1'b1;
            found_in  = match;
            off_in    = match ? rx1 : '0;
            lvl_in    = fill_ff;
            last_in   = 1'b1;
         end else begin
            rp_in  = sp_ff;
            lww_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_INIT;
         needle_ff <= NEEDLE_RESET;
         nl_ff     <= NL_RESET;
         rp_ff     <= '0;
         wp_ff     <= '0;
         lww_ff    <= 1'b0;
         dv_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         cap_ff    <= cap_in;
         needle_ff <= needle_in;
         nl_ff     <= nl_in;
         rp_ff     <= rp_in;
         wp_ff     <= wp_in;
         lww_ff    <= lww_in;
         dv_ff     <= cmd.issue;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff     <= sp_in;
      target_ff <= target_in;
      issued_ff <= issued_in;
      rx_ff     <= rx_in;
      fill_ff   <= fill_in;
      find_ff   <= find_in;
      hist_ff   <= hist_in;
      byte_ff   <= byte_in;
      valid_ff  <= valid_in;
      acc_ff    <= acc_in;
      found_ff  <= found_in;
      off_ff    <= off_in;
      lvl_ff    <= lvl_in;
      last_ff   <= last_in;
   end

   brb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (do_write),
      .waddr (wp_ff),
      .wdata (req_data_byte),
      .raddr (sp_ff),
      .rdata (rdata)
   );

   assign rsp_strobe           = strobe_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_byte_valid       = valid_ff;
   assign rsp_write_accepted   = acc_ff;
   assign rsp_found            = found_ff;
   assign rsp_match_end_offset = off_ff;
   assign rsp_fill_level       = lvl_ff;
   assign rsp_last             = last_ff;

endmodule

// ===== src/byte_ring_buffer_with_delimiter_search_core.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_delimiter_search_core
// byte ring buffer with write, counted read and delimiter find
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  req       start & !busy          action, data_byte, read_count, search_window
//  rsp       rsp_strobe, one cycle  out_byte ... last
//  csr       csr_write_enable       csr_index, csr_write_data
//
// write, empty read, failed find precheck, other action: result in the cycle after the item
// read of n bytes: one byte per cycle through the ram read
// find over w bytes: one compare per ram read, stops at the first match
// reset clears read and write pointers and restores register defaults, storage is not cleared
// results cannot be held off by the receiver
module byte_ring_buffer_with_delimiter_search_core #(
   parameter int DEPTH      = brb_pkg::DEPTH_DEFAULT,
   parameter int MAX_NEEDLE = brb_pkg::MAX_NEEDLE_DEFAULT,
   parameter int MAX_READ   = brb_pkg::MAX_READ_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [7:0]                    req_data_byte,
   input  logic [brb_pkg::CNT_W-1:0]     req_read_count,
   input  logic [brb_pkg::WIN_W-1:0]     req_search_window,
   input  logic                          csr_write_enable,
   input  logic [brb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [brb_pkg::NEEDLE_W-1:0]  csr_write_data,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_write_accepted,
   output logic                          rsp_found,
   output logic [brb_pkg::WIN_W-1:0]     rsp_match_end_offset,
   output logic [brb_pkg::FILL_W-1:0]    rsp_fill_level,
   output logic                          rsp_last
);

   import brb_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       busy_w;

   brb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy_w)
   );

   brb_dp #(
      .DEPTH      (DEPTH),
      .MAX_NEEDLE (MAX_NEEDLE),
      .MAX_READ   (MAX_READ)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_action           (req_action),
      .req_data_byte        (req_data_byte),
      .req_read_count       (req_read_count),
      .req_search_window    (req_search_window),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_strobe           (rsp_strobe),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_write_accepted   (rsp_write_accepted),
      .rsp_found            (rsp_found),
      .rsp_match_end_offset (rsp_match_end_offset),
      .rsp_fill_level       (rsp_fill_level),
      .rsp_last             (rsp_last)
   );

   assign busy = busy_w;

   // a write always answers in the next cycle with a single final result
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_WRITE) |=> rsp_strobe && rsp_last)
      else $error("write result missing");

   // results without a byte are always the only result of their item
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_byte_valid |-> rsp_last)
      else $error("non-byte result not final");

   // a found delimiter ends at least one byte past the read pointer
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |-> rsp_match_end_offset != '0)
      else $error("zero match offset");

   // no item is accepted while a scan is running
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.accept)
      else $error("item taken while busy");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte ring buffer: random writes, reads and
// delimiter finds against a behavioral copy of the buffer, several capacity
// and delimiter settings, result items compared field by field in order
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import brb_pkg::*;

   localparam int DEPTH    = 1024;
   localparam int MAX_RD   = 64;
   localparam int MAX_NL   = 8;
   localparam int LIMIT    = 2000000;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic              byte_valid;
      logic              write_accepted;
      logic              found;
      logic [WIN_W-1:0]  match_end_offset;
      logic [FILL_W-1:0] fill_level;
      logic              last;
   } rsp_type;

   int unsigned error_count = 0;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   class ring_scoreboard;
      logic [7:0]  mem [DEPTH];
      int unsigned rd_ptr, wr_ptr, cap, nl;
      logic        wrote_last;
      logic [63:0] needle;
      rsp_type     pending [$];

      function new();
         cap = CAP_RESET; needle = NEEDLE_RESET; nl = 32'(NL_RESET);
         clear();
      endfunction

      function void clear();
         rd_ptr = 0; wr_ptr = 0; wrote_last = 1'b0;
      endfunction

      function int unsigned level();
         if (rd_ptr == wr_ptr) return wrote_last ? cap : 0;
         return (wr_ptr + cap - rd_ptr) % cap;
      endfunction

      function void set_reg(input csr_index_type idx, input logic [63:0] val);
         int unsigned v;
         case (idx)
            CSR_CAPACITY: begin
               v = 32'(val[10:0]);
               if (v == 0) v = 1;
               if (v > DEPTH) v = DEPTH;
               cap = v;
               clear();
            end
            CSR_NEEDLE: needle = val;
            CSR_NEEDLE_LEN: begin
               v = 32'(val[3:0]);
               if (v == 0) v = 1;
               if (v > MAX_NL) v = MAX_NL;
               nl = v;
            end
            default: ;
         endcase
      endfunction

      function void note_item(input action_type act, input logic [7:0] data,
                              input int unsigned cnt, input int unsigned win);
         rsp_type r;
         int unsigned n, fill;
         logic [7:0] got [$];
         logic same;
         r = '0; r.last = 1'b1;
         case (act)
            ACT_WRITE: begin
               if (!(wrote_last && rd_ptr == wr_ptr)) begin
                  mem[wr_ptr] = data;
                  wr_ptr = (wr_ptr + 1) % cap;
                  wrote_last = 1'b1;
                  r.write_accepted = 1'b1;
               end
               r.fill_level = FILL_W'(level());
               pending.push_back(r);
            end
            ACT_READ: begin
               fill = level();
               n = cnt > MAX_RD ? MAX_RD : cnt;
               if (n > fill) n = fill;
               if (n == 0) begin
                  r.fill_level = FILL_W'(fill);
                  pending.push_back(r);
               end else begin
                  for (int k = 0; k < n; k++) begin
                     got.push_back(mem[rd_ptr]);
                     rd_ptr = (rd_ptr + 1) % cap;
                  end
                  wrote_last = 1'b0;
                  fill = level();
                  for (int k = 0; k < n; k++) begin
                     r = '0;
                     r.out_byte = got[k]; r.byte_valid = 1'b1;
                     r.fill_level = FILL_W'(fill); r.last = (k == n - 1);
                     pending.push_back(r);
                  end
               end
            end
            ACT_FIND: begin
               fill = level();
               r.fill_level = FILL_W'(fill);
               if (!(fill < win || fill < nl || nl > win)) begin
                  for (int s = 0; s + nl <= win; s++) begin
                     same = 1'b1;
                     for (int i = 0; i < nl; i++)
                        if (mem[(rd_ptr + s + i) % cap] != needle[8*i +: 8]) same = 1'b0;
                     if (same) begin
                        r.found = 1'b1; r.match_end_offset = WIN_W'(s + nl);
                        break;
                     end
                  end
               end
               pending.push_back(r);
            end
            default: begin
               r.fill_level = FILL_W'(level());
               pending.push_back(r);
            end
         endcase
      endfunction

      function string check_result(input rsp_type got);
         rsp_type w;
         if (pending.size() == 0) return "result with nothing expected";
         w = pending.pop_front();
         if (got !== w)
            return $sformatf({"byte %h/%h v %b/%b acc %b/%b fnd %b/%b",
                              " off %0d/%0d fill %0d/%0d last %b/%b"},
               got.out_byte, w.out_byte, got.byte_valid, w.byte_valid,
               got.write_accepted, w.write_accepted, got.found, w.found,
               got.match_end_offset, w.match_end_offset,
               got.fill_level, w.fill_level, got.last, w.last);
         return "";
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_action = '0;
   logic [7:0] req_data_byte = '0;
   logic [CNT_W-1:0] req_read_count = '0;
   logic [WIN_W-1:0] req_search_window = '0;
   logic csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [NEEDLE_W-1:0] csr_write_data = '0;
   logic rsp_strobe;
   logic [7:0] rsp_out_byte;
   logic rsp_byte_valid, rsp_write_accepted, rsp_found, rsp_last;
   logic [WIN_W-1:0] rsp_match_end_offset;
   logic [FILL_W-1:0] rsp_fill_level;

   ring_scoreboard sb = new();
   int unsigned cycle_count = 0;
   bit calm = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   byte_ring_buffer_with_delimiter_search_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_data_byte(req_data_byte),
      .req_read_count(req_read_count), .req_search_window(req_search_window),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .rsp_strobe(rsp_strobe),
      .rsp_out_byte(rsp_out_byte), .rsp_byte_valid(rsp_byte_valid),
      .rsp_write_accepted(rsp_write_accepted), .rsp_found(rsp_found),
      .rsp_match_end_offset(rsp_match_end_offset),
      .rsp_fill_level(rsp_fill_level), .rsp_last(rsp_last)
   );

   always @(posedge clock) begin
      string msg;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         msg = sb.check_result({rsp_out_byte, rsp_byte_valid, rsp_write_accepted,
            rsp_found, rsp_match_end_offset, rsp_fill_level, rsp_last});
         if (msg != "") report(msg);
      end
      if (cycle_count >= LIMIT) begin
         $display("timeout");
         $display("FAIL byte_ring_buffer_with_delimiter_search_core");
         $finish;
      end
   end

   // stop sending and wait until every expected result has come
   task automatic wait_results();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      wait_results();
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_write_enable <= 0;
   endtask

   // waits out outstanding results plus slack for a find still scanning
   task automatic drain();
      wait_results();
      repeat (DEPTH + 20) @(posedge clock);
   endtask

   task automatic send(input action_type act, input logic [7:0] data,
                       input int unsigned cnt, input int unsigned win);
      while (!calm && $urandom_range(99) < 15) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_action <= act;
      req_data_byte <= data;
      req_read_count <= CNT_W'(cnt);
      req_search_window <= WIN_W'(win);
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(act, data, cnt, win);
   endtask

   task automatic random_item();
      int unsigned p;
      logic [63:0] nb;
      int unsigned k;
      p = $urandom_range(99);
      nb = sb.needle;
      k = sb.nl;
      if (p < 45) begin
         // plant the delimiter now and then so finds hit
         if ($urandom_range(9) == 0) begin
            for (int i = 0; i < k; i++) send(ACT_WRITE, nb[8*i +: 8], 0, 0);
         end else send(ACT_WRITE, 8'($urandom_range(255)), $urandom_range(127),
                       $urandom_range(2047));
      end else if (p < 70)
         send(ACT_READ, 8'($urandom_range(255)),
              $urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(8),
              $urandom_range(2047));
      else if (p < 96)
         send(ACT_FIND, 8'($urandom_range(255)), $urandom_range(127),
              $urandom_range(3) == 0 ? $urandom_range(2047) : $urandom_range(sb.level()));
      else
         send(ACT_NONE, 8'($urandom_range(255)), $urandom_range(127),
              $urandom_range(2047));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty read/find, undefined action, clamp, fill/overflow, finds
      calm = 1;
      send(ACT_READ, 8'h00, 5, 0);
      send(ACT_FIND, 8'h00, 0, 2);
      send(ACT_NONE, 8'hFF, 127, 2047);
      write_reg(CSR_CAPACITY, 64'd0);
      write_reg(CSR_UNUSED, 64'hFFFF);
      send(ACT_WRITE, 8'hFF, 0, 0);
      send(ACT_WRITE, 8'h00, 0, 0);
      send(ACT_READ, 8'h00, 0, 0);
      send(ACT_READ, 8'h00, 127, 0);
      drain();
      write_reg(CSR_CAPACITY, 64'd4);
      write_reg(CSR_NEEDLE, 64'h0000_0000_0000_0A0D);
      write_reg(CSR_NEEDLE_LEN, 64'd0);
      send(ACT_WRITE, 8'h0D, 0, 0);
      send(ACT_WRITE, 8'h0A, 0, 0);
      send(ACT_WRITE, 8'h0D, 0, 0);
      send(ACT_FIND, 8'h00, 0, 0);
      send(ACT_FIND, 8'h00, 0, 3);
      send(ACT_FIND, 8'h00, 0, 2047);
      send(ACT_READ, 8'h00, 2, 0);
      send(ACT_WRITE, 8'h0A, 0, 0);
      send(ACT_WRITE, 8'h55, 0, 0);
      send(ACT_WRITE, 8'hAA, 0, 0);
      send(ACT_FIND, 8'h00, 0, 4);
      drain();
      write_reg(CSR_NEEDLE_LEN, 64'd15);
      write_reg(CSR_CAPACITY, 64'd2047);
      calm = 0;

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_CAPACITY, 64'd8); write_reg(CSR_NEEDLE_LEN, 64'd1);
                     write_reg(CSR_NEEDLE, {$urandom, $urandom} & 64'h3); end
            1: begin write_reg(CSR_CAPACITY, 64'd1024); write_reg(CSR_NEEDLE_LEN, 64'd2);
                     write_reg(CSR_NEEDLE, 64'h0302); end
            2: begin write_reg(CSR_CAPACITY, 64'd1); write_reg(CSR_NEEDLE_LEN, 64'd8);
                     write_reg(CSR_NEEDLE, 64'hFFFF_FFFF_FFFF_FFFF); end
            3: begin write_reg(CSR_CAPACITY, 64'd37); write_reg(CSR_NEEDLE_LEN, 64'd3);
                     write_reg(CSR_NEEDLE, {$urandom, $urandom}); end
            4: begin write_reg(CSR_CAPACITY, 64'd16); write_reg(CSR_NEEDLE_LEN, 64'd9);
                     write_reg(CSR_NEEDLE, 64'h0); end
            default: begin write_reg(CSR_CAPACITY, 64'($urandom_range(1, 200)));
                     write_reg(CSR_NEEDLE_LEN, 64'd2); write_reg(CSR_NEEDLE, 64'h0101); end
         endcase
         calm = (ph == 1);
         for (int i = 0; i < 65; i++) begin
            random_item();
            if (i == 30) wait_results();
         end
         drain();
      end

      if (error_count == 0)
         $display("PASS byte_ring_buffer_with_delimiter_search_core");
      else
         $display("FAIL byte_ring_buffer_with_delimiter_search_core");
      $finish;
   end
endmodule
